@@ rtl/tsps_pkg.sv @@
// ----------------------------------------------------------------------------
// tsps_pkg
// Shared types and constants for the traffic signal phase sequencer.
// ----------------------------------------------------------------------------
package tsps_pkg;

   localparam int PHASES       = 4;
   localparam int TIME_BITS    = 10;
   localparam int ROAD_BITS    = 2;
   localparam int LANE_BITS    = 1;

   localparam int SLOT_BITS    = 10;
   localparam int GROUP_BITS   = 3 * SLOT_BITS;
   localparam int TIMES_BITS   = 2 * GROUP_BITS;
   localparam int ELAPSED_BITS = 12;
   localparam int PHASE_BITS   = 2;
   localparam int COUNT_BITS   = 3;
   localparam int MASK_BITS    = 64;
   localparam int MOVE_BITS    = 2 * (ROAD_BITS + LANE_BITS);
   localparam int MIDX_BITS    = 6;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_IDX_BITS  = 3;

   typedef enum logic [1:0] {
      COLOUR_GREEN = 2'd0,
      COLOUR_AMBER = 2'd1,
      COLOUR_RED   = 2'd2
   } colour_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_PHASE_COUNT = 3'd0,
      REG_TIMES01     = 3'd1,
      REG_TIMES23     = 3'd2,
      REG_MOVES0      = 3'd3,
      REG_MOVES1      = 3'd4,
      REG_MOVES2      = 3'd5,
      REG_MOVES3      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]                phase_count;
      logic [TIMES_BITS-1:0]                times01;
      logic [TIMES_BITS-1:0]                times23;
      logic [PHASES-1:0][MASK_BITS-1:0]     movements;
   } cfg_type;

endpackage

@@ rtl/tsps_csr.sv @@
// ----------------------------------------------------------------------------
// tsps_csr
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module tsps_csr
   import tsps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write_en;

   // Registers sit on 8-byte boundaries.
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_count <= COUNT_BITS'(1);
         cfg_ff.times01     <= '0;
         cfg_ff.times23     <= '0;
         cfg_ff.movements   <= '0;
      end else if (write_en) begin
         unique case (index)
            REG_PHASE_COUNT: cfg_ff.phase_count  <= csr_pwdata[COUNT_BITS-1:0];
            REG_TIMES01:     cfg_ff.times01      <= csr_pwdata[TIMES_BITS-1:0];
            REG_TIMES23:     cfg_ff.times23      <= csr_pwdata[TIMES_BITS-1:0];
            REG_MOVES0:      cfg_ff.movements[0] <= csr_pwdata;
            REG_MOVES1:      cfg_ff.movements[1] <= csr_pwdata;
            REG_MOVES2:      cfg_ff.movements[2] <= csr_pwdata;
            REG_MOVES3:      cfg_ff.movements[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PHASE_COUNT: csr_prdata = CSR_DATA_BITS'(cfg_ff.phase_count);
         REG_TIMES01:     csr_prdata = CSR_DATA_BITS'(cfg_ff.times01);
         REG_TIMES23:     csr_prdata = CSR_DATA_BITS'(cfg_ff.times23);
         REG_MOVES0:      csr_prdata = cfg_ff.movements[0];
         REG_MOVES1:      csr_prdata = cfg_ff.movements[1];
         REG_MOVES2:      csr_prdata = cfg_ff.movements[2];
         REG_MOVES3:      csr_prdata = cfg_ff.movements[3];
         default:         csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/traffic_signal_phase_sequencer.sv @@
// ----------------------------------------------------------------------------
// traffic_signal_phase_sequencer
// Steps an intersection through up to four signal phases and answers
// movement colour queries.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  req_      in         tuser: action; tdata: roads and lanes of a movement
//  rsp_      out        tdata: light colour, current phase index
//  csr_      in/out     APB-style registers, 64-bit data, 8-byte spacing
//
// One word is accepted per cycle while req_tready is high. A word is captured
// in an input register, evaluated when the output register is empty or being
// drained, and its result is written to the output register, from which it is
// offered on rsp_. The phase state is updated in the same cycle that the output
// register is loaded. When the output register is held by rsp_tready low, the
// input register fills and then req_tready drops. Reset is synchronous and
// returns all phase colors to red.
//
module traffic_signal_phase_sequencer
   import tsps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Input words
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [0:0]               req_tuser,   // [0] action: 0 tick, 1 query
   input  logic [7:0]               req_tdata,   // [1:0] source_road, [2] source_lane,
                                                 // [4:3] target_road, [5] target_lane
   // Result words
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // [1:0] light_colour, [3:2] phase_now
   // Configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;

   tsps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic                 in_valid_ff, in_valid_in;
   logic                 in_action_ff;
   logic [ROAD_BITS-1:0] in_src_road_ff, in_dst_road_ff;
   logic [LANE_BITS-1:0] in_src_lane_ff, in_dst_lane_ff;
   logic                 req_take;
   logic                 fire;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_colour_ff;
   logic [PHASE_BITS-1:0] rsp_phase_ff;

   // The evaluation stage fires when it holds a word and the output register
   // is empty or is being drained in this cycle.
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff   <= req_tuser[0];
         in_src_road_ff <= req_tdata[1:0];
         in_src_lane_ff <= req_tdata[2];
         in_dst_road_ff <= req_tdata[4:3];
         in_dst_lane_ff <= req_tdata[5];
      end
   end

   // ------------------------------------------------------------------
   // Phase state
   // ------------------------------------------------------------------
   logic [ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   colour_type              colour_ff [PHASES];
   colour_type              colour_in [PHASES];

   // Timing of the current phase: pick the packed word, then the group.
   logic [TIMES_BITS-1:0]   times_word;
   logic [GROUP_BITS-1:0]   times_group;
   logic [TIME_BITS-1:0]    green_t, amber_t, red_t;
   logic [ELAPSED_BITS-1:0] bump, green_end, amber_end, red_end;
   logic [COUNT_BITS-1:0]   active;
   logic [COUNT_BITS-1:0]   phase_inc;

   assign times_word  = phase_ff[1] ? cfg.times23 : cfg.times01;
   assign times_group = phase_ff[0] ? times_word[TIMES_BITS-1:GROUP_BITS]
                                    : times_word[GROUP_BITS-1:0];
   assign green_t     = times_group[TIME_BITS-1:0];
   assign amber_t     = times_group[SLOT_BITS +: TIME_BITS];
   assign red_t       = times_group[2*SLOT_BITS +: TIME_BITS];

   // The three thresholds fit in the elapsed width, so no sum overflows.
   assign bump      = elapsed_ff + ELAPSED_BITS'(1);
   assign green_end = ELAPSED_BITS'(green_t);
   assign amber_end = green_end + ELAPSED_BITS'(amber_t);
   assign red_end   = amber_end + ELAPSED_BITS'(red_t);

   // A count of zero behaves as one phase, and counts above the phase
   // total behave as the full set.
   always_comb begin
      active = cfg.phase_count;
      if (cfg.phase_count == '0) begin
         active = COUNT_BITS'(1);
      end else if (cfg.phase_count > COUNT_BITS'(PHASES)) begin
         active = COUNT_BITS'(PHASES);
      end
   end

   assign phase_inc = COUNT_BITS'(phase_ff) + COUNT_BITS'(1);

   // Query path: build the movement index and look it up in the mask of
   // the current phase.
   logic [MOVE_BITS-1:0] move;
   logic [MIDX_BITS-1:0] move_idx;
   logic [MASK_BITS-1:0] cur_mask;
   logic                 released;

   assign move     = {in_src_road_ff, in_src_lane_ff, in_dst_road_ff, in_dst_lane_ff};
   assign move_idx = MIDX_BITS'(move);
   assign cur_mask = cfg.movements[phase_ff];
   assign released = cur_mask[move_idx];

   logic [1:0] result_colour;

   always_comb begin
      elapsed_in = elapsed_ff;
      phase_in   = phase_ff;
      for (int i = 0; i < PHASES; i++) begin
         colour_in[i] = colour_ff[i];
      end
      result_colour = COLOUR_RED;

      if (!in_action_ff) begin
         // Tick: advance the count and recolor the current phase.
         elapsed_in = bump;
         if (bump > green_end) begin
            if (bump > amber_end) begin
               colour_in[phase_ff] = COLOUR_RED;
               if (bump > red_end) begin
                  // Phase is over: clear the count and move to the next one.
                  elapsed_in = '0;
                  if (phase_inc >= active) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_inc[PHASE_BITS-1:0];
                  end
               end
            end else begin
               colour_in[phase_ff] = COLOUR_AMBER;
            end
         end else begin
            colour_in[phase_ff] = COLOUR_GREEN;
         end
         result_colour = colour_in[phase_in];
      end else begin
         // Query: the stored colour if this phase releases the movement.
         if (released) begin
            result_colour = colour_ff[phase_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         phase_ff   <= '0;
         for (int i = 0; i < PHASES; i++) begin
            colour_ff[i] <= COLOUR_RED;
         end
      end else if (fire) begin
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
         for (int i = 0; i < PHASES; i++) begin
            colour_ff[i] <= colour_in[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_colour_ff <= result_colour;
         rsp_phase_ff  <= phase_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_phase_ff, rsp_colour_ff};

endmodule

@@ rtl/tsps_checker.sv @@
// ----------------------------------------------------------------------------
// tsps_checker
// Port-level checks for the traffic signal phase sequencer.
// ----------------------------------------------------------------------------
module tsps_checker
   import tsps_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A held result does not change while it waits.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The colour is always one of the three lamp states.
   a_colour_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == COLOUR_GREEN || rsp_tdata[1:0] == COLOUR_AMBER
                      || rsp_tdata[1:0] == COLOUR_RED))
      else $error("illegal colour code");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Padding bits of the result word stay zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] == 4'b0000)
      else $error("result padding not zero");

endmodule

bind traffic_signal_phase_sequencer tsps_checker u_tsps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
